FILE: sv/gts_pkg.sv
// ----------------------------------------------------------------------------
// gts_pkg
// shared types and constants for the gait trajectory sequencer
// ----------------------------------------------------------------------------
package gts_pkg;

	localparam int MOTORS = 18;
	localparam int MOTOR_W = 5;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_FEEDBACK = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [2:0] G_NULL = 3'd0;
	localparam logic [2:0] G_STAND = 3'd1;
	localparam logic [2:0] G_HOME = 3'd4;
	localparam logic [2:0] G_LAST = 3'd6;

	localparam logic [1:0] RS_NONE = 2'd0;
	localparam logic [1:0] RS_RUN = 2'd1;
	localparam logic [1:0] RS_STOP = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_COPY,
		ST_EMIT
	} state_t;

	// what the per-motor sweep does to the drive stores
	typedef enum logic [1:0] {
		DRV_KEEP,
		DRV_HELD,
		DRV_ROW
	} drive_op_t;

	typedef struct packed {
		logic      decide;
		logic      sweep_start;
		logic      sweep_en;
		logic      emit_en;
	} cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic emit_last;
	} status_t;

	function automatic logic [MOTOR_W-1:0] phys_to_logical(input logic [MOTOR_W-1:0] p);
		logic [MOTOR_W-1:0] r;
		case (p)
			5'd0: r = 5'd15;
			5'd1: r = 5'd17;
			5'd2: r = 5'd16;
			5'd3: r = 5'd12;
			5'd4: r = 5'd14;
			5'd5: r = 5'd13;
			5'd6: r = 5'd9;
			5'd7: r = 5'd11;
			5'd8: r = 5'd10;
			5'd9: r = 5'd2;
			5'd10: r = 5'd0;
			5'd11: r = 5'd1;
			5'd12: r = 5'd3;
			5'd13: r = 5'd5;
			5'd14: r = 5'd4;
			5'd15: r = 5'd7;
			5'd16: r = 5'd8;
			5'd17: r = 5'd6;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/gait_trajectory_sequencer.sv
// ----------------------------------------------------------------------------
// gait_trajectory_sequencer
// plays back joint tables and sends eighteen motor commands per tick
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     in_valid / in_stall  action .. time_now
//  output    out_valid/ out_stall motor_out .. step_done
//  config    avoid_enable_we      avoid_enable
// a load, feedback or clear request is stored in the cycle it is taken
// a tick holds the input through its steps: accept, decide, a sweep over the
// 18 motors through the single-port table memory, landing the last read, then
// 18 results one per cycle while the output is not stalled
// output stalls hold the emit sweep; no input is taken during a tick
// reset clears all stores but the table memory, which needs no clearing
module gait_trajectory_sequencer #(
	parameter int MOVE_ROWS = 1024,
	parameter int TURN_ROWS = 1024,
	parameter int START_ROWS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avoid_enable_we,
	input  logic               avoid_enable,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [2:0]         table_select,
	input  logic [9:0]         row,
	input  logic [4:0]         motor,
	input  logic signed [31:0] position,
	input  logic signed [31:0] velocity,
	input  logic signed [31:0] torque,
	input  logic [2:0]         requested_gait,
	input  logic [31:0]        time_now,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         motor_out,
	output logic signed [31:0] cmd_position,
	output logic signed [31:0] cmd_velocity,
	output logic signed [31:0] cmd_torque,
	output logic               last_motor,
	output logic [2:0]         gait_next,
	output logic               finished,
	output logic               step_done
);
	logic             avoid_q;
	logic             in_take;
	gts_pkg::cmd_t    cmd;
	gts_pkg::status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avoid_q <= 1'b0;
		end else if (avoid_enable_we) begin
			avoid_q <= avoid_enable;
		end
	end

	gts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.in_take   (in_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	gts_datapath #(
		.MOVE_ROWS  (MOVE_ROWS),
		.TURN_ROWS  (TURN_ROWS),
		.START_ROWS (START_ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.avoid_en       (avoid_q),
		.in_take        (in_take),
		.action         (action),
		.table_select   (table_select),
		.row            (row),
		.motor          (motor),
		.position       (position),
		.velocity       (velocity),
		.torque         (torque),
		.requested_gait (requested_gait),
		.time_now       (time_now),
		.cmd            (cmd),
		.status         (status),
		.motor_out      (motor_out),
		.cmd_position   (cmd_position),
		.cmd_velocity   (cmd_velocity),
		.cmd_torque     (cmd_torque),
		.last_motor     (last_motor),
		.gait_next      (gait_next),
		.finished       (finished),
		.step_done      (step_done)
	);
endmodule

FILE: sv/gts_ram.sv
// ----------------------------------------------------------------------------
// gts_ram
// generic single-port ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
module gts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: sv/gts_datapath.sv
// ----------------------------------------------------------------------------
// gts_datapath
// motor stores, table memory, gait decision and result register
// ----------------------------------------------------------------------------
module gts_datapath #(
	parameter int MOVE_ROWS = 1024,
	parameter int TURN_ROWS = 1024,
	parameter int START_ROWS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                avoid_en,
	input  logic                in_take,
	input  logic [1:0]          action,
	input  logic [2:0]          table_select,
	input  logic [9:0]          row,
	input  logic [4:0]          motor,
	input  logic signed [31:0]  position,
	input  logic signed [31:0]  velocity,
	input  logic signed [31:0]  torque,
	input  logic [2:0]          requested_gait,
	input  logic [31:0]         time_now,
	input  gts_pkg::cmd_t       cmd,
	output gts_pkg::status_t    status,
	output logic [4:0]          motor_out,
	output logic signed [31:0]  cmd_position,
	output logic signed [31:0]  cmd_velocity,
	output logic signed [31:0]  cmd_torque,
	output logic                last_motor,
	output logic [2:0]          gait_next,
	output logic                finished,
	output logic                step_done
);
	localparam int ROWS = 2 * MOVE_ROWS + START_ROWS + 2 * TURN_ROWS;
	localparam int DEPTH = ROWS * gts_pkg::MOTORS;
	localparam int AW = $clog2(DEPTH);
	localparam int RW = $clog2(ROWS);
	localparam int MAXL = (MOVE_ROWS > TURN_ROWS) ?
		((MOVE_ROWS > START_ROWS) ? MOVE_ROWS : START_ROWS) :
		((TURN_ROWS > START_ROWS) ? TURN_ROWS : START_ROWS);
	localparam int LW = $clog2(MAXL + 1);
	localparam int M = gts_pkg::MOTORS;

	logic [31:0] sen_p_q [M], sen_v_q [M], sen_t_q [M];
	logic [31:0] hld_p_q [M], hld_v_q [M], hld_t_q [M];
	logic [31:0] drv_p_q [M], drv_v_q [M], drv_t_q [M];
	logic [2:0]  active_q;
	logic [31:0] start_q;
	logic [1:0]  run_q;
	logic        flag_q;

	// tick decision, registered
	logic [2:0]              next_q;
	gts_pkg::drive_op_t      op_q;
	logic                    cap_q;
	logic [RW-1:0]           rowsel_q;

	logic [4:0] cnt_q;
	logic       rd_valid_q;
	logic [4:0] rd_motor_q;

	// table span
	function automatic logic [RW-1:0] span_base(input logic [2:0] s);
		logic [RW-1:0] b;
		case (s)
			3'd0: b = '0;
			3'd1: b = RW'(MOVE_ROWS);
			3'd2: b = RW'(2 * MOVE_ROWS);
			3'd3: b = RW'(2 * MOVE_ROWS + START_ROWS);
			default: b = RW'(2 * MOVE_ROWS + START_ROWS + TURN_ROWS);
		endcase
		return b;
	endfunction

	function automatic logic [LW-1:0] span_len(input logic [2:0] s);
		logic [LW-1:0] l;
		case (s)
			3'd0, 3'd1: l = LW'(MOVE_ROWS);
			3'd2: l = LW'(START_ROWS);
			default: l = LW'(TURN_ROWS);
		endcase
		return l;
	endfunction

	// load address, (span base + row) * 18 + motor
	logic [2:0]    ld_sel;
	logic          ld_ok;
	logic [AW-1:0] ld_addr;
	logic [AW-1:0] rd_addr;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_rdata;

	assign ld_sel = table_select;
	assign ld_ok = (table_select <= 3'd4) && (motor < 5'(M)) &&
		({{(32-10){1'b0}}, row} < 32'(span_len(ld_sel)));
	assign ld_addr = AW'((32'(span_base(ld_sel)) + 32'(row)) * 32'(M) + 32'(motor));
	assign rd_addr = AW'(32'(rowsel_q) * 32'(M) + 32'(cnt_q));
	assign ram_we = in_take && (action == gts_pkg::ACT_LOAD) && ld_ok;
	assign ram_addr = ram_we ? ld_addr : rd_addr;

	gts_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (position),
		.rdata (ram_rdata)
	);

	// decision combinational
	logic [2:0]         sel_g;
	logic [31:0]        diff;
	logic [31:0]        last_row;
	logic [31:0]        idx;
	logic [2:0]         d_next;
	gts_pkg::drive_op_t d_op;
	logic               d_cap;
	logic [RW-1:0]      d_row;
	logic               d_new;

	assign sel_g = requested_gait - 3'd2;
	assign diff = time_now - start_q;
	assign last_row = 32'(span_len(sel_g)) - 32'd1;
	assign idx = (diff > last_row) ? last_row : diff;
	assign d_new = requested_gait != active_q;

	always_comb begin
		d_next = requested_gait;
		d_op = gts_pkg::DRV_KEEP;
		d_cap = 1'b0;
		d_row = span_base(sel_g);
		if (requested_gait == gts_pkg::G_NULL) begin
			d_next = gts_pkg::G_STAND;
			d_op = gts_pkg::DRV_HELD;
			d_cap = 1'b1;
		end else if (requested_gait == gts_pkg::G_STAND) begin
			d_op = gts_pkg::DRV_HELD;
			d_cap = d_new;
		end else if (requested_gait <= gts_pkg::G_LAST) begin
			d_op = gts_pkg::DRV_ROW;
			if (!d_new) begin
				d_row = RW'(32'(span_base(sel_g)) + idx);
				if (idx == last_row) begin
					d_next = gts_pkg::G_STAND;
					d_cap = 1'b1;
				end
			end
		end
	end

	// scalar state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= gts_pkg::G_NULL;
			start_q <= '0;
			run_q <= gts_pkg::RS_NONE;
			flag_q <= 1'b0;
		end else if (in_take && action == gts_pkg::ACT_CLEAR) begin
			flag_q <= 1'b0;
		end else if (cmd.decide) begin
			if (requested_gait == gts_pkg::G_NULL) begin
				run_q <= gts_pkg::RS_STOP;
			end else if (requested_gait <= gts_pkg::G_LAST) begin
				if (d_new) begin
					active_q <= requested_gait;
					start_q <= time_now;
					if (requested_gait != gts_pkg::G_STAND) begin
						run_q <= gts_pkg::RS_RUN;
					end
				end else if (requested_gait != gts_pkg::G_STAND && d_cap) begin
					run_q <= gts_pkg::RS_STOP;
					if (requested_gait != gts_pkg::G_HOME && avoid_en) begin
						flag_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			next_q <= d_next;
			op_q <= d_op;
			cap_q <= d_cap;
			rowsel_q <= d_row;
		end
	end

	// sweep counter, one logical motor per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_valid_q <= 1'b0;
			rd_motor_q <= '0;
		end else begin
			rd_valid_q <= cmd.sweep_en && (op_q == gts_pkg::DRV_ROW);
			rd_motor_q <= cnt_q;
			if (cmd.sweep_start) begin
				cnt_q <= '0;
			end else if (cmd.sweep_en || cmd.emit_en) begin
				cnt_q <= (cnt_q == 5'(M - 1)) ? '0 : cnt_q + 5'd1;
			end
		end
	end

	// sweep is done once no read is issued and none is left to land in the drive store
	assign status.sweep_done = !cmd.sweep_en && !rd_valid_q;
	assign status.emit_last = cnt_q == 5'(M - 1);

	// motor stores
	logic [4:0] fb_lm;
	assign fb_lm = gts_pkg::phys_to_logical(motor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < M; i++) begin
				sen_p_q[i] <= '0; sen_v_q[i] <= '0; sen_t_q[i] <= '0;
				hld_p_q[i] <= '0; hld_v_q[i] <= '0; hld_t_q[i] <= '0;
				drv_p_q[i] <= '0; drv_v_q[i] <= '0; drv_t_q[i] <= '0;
			end
		end else begin
			if (in_take && action == gts_pkg::ACT_FEEDBACK && motor < 5'(M)) begin
				sen_p_q[fb_lm] <= position;
				sen_v_q[fb_lm] <= velocity;
				sen_t_q[fb_lm] <= torque;
			end
			// held and drive from held are whole-array copies, done at sweep start
			if (cmd.sweep_start) begin
				for (int i = 0; i < M; i++) begin
					if (cap_q) begin
						hld_p_q[i] <= sen_p_q[i];
						hld_v_q[i] <= sen_v_q[i];
						hld_t_q[i] <= sen_t_q[i];
					end
					if (op_q == gts_pkg::DRV_HELD) begin
						drv_p_q[i] <= cap_q ? sen_p_q[i] : hld_p_q[i];
						drv_v_q[i] <= cap_q ? sen_v_q[i] : hld_v_q[i];
						drv_t_q[i] <= cap_q ? sen_t_q[i] : hld_t_q[i];
					end
				end
			end
			if (rd_valid_q) begin
				drv_p_q[rd_motor_q] <= ram_rdata;
			end
		end
	end

	// result register
	logic [4:0] out_lm;
	assign out_lm = gts_pkg::phys_to_logical(cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.emit_en) begin
			motor_out <= cnt_q;
			cmd_position <= drv_p_q[out_lm];
			cmd_velocity <= drv_v_q[out_lm];
			cmd_torque <= drv_t_q[out_lm];
			last_motor <= cnt_q == 5'(M - 1);
			gait_next <= next_q;
			finished <= run_q == gts_pkg::RS_STOP;
			step_done <= flag_q;
		end
	end

	sweep_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < 5'(M)) else $error("motor counter out of range");
	write_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !cmd.sweep_en) else $error("table write during sweep");
	readback_follows: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_q |-> $past(cmd.sweep_en)) else $error("stray table read");
endmodule

FILE: sv/gts_ctrl.sv
// ----------------------------------------------------------------------------
// gts_ctrl
// controller: decide, copy sweep over motors, emit eighteen results
// ----------------------------------------------------------------------------
module gts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       action,
	output logic             in_take,
	output logic             out_valid,
	input  logic             out_stall,
	output gts_pkg::cmd_t    cmd,
	input  gts_pkg::status_t status
);
	gts_pkg::state_t state_q, state_d;
	logic            ov_q;
	logic            out_take;
	logic            swept_q;

	assign out_valid = ov_q;
	assign out_take = ov_q && !out_stall;
	assign in_stall = state_q != gts_pkg::ST_IDLE;
	assign in_take = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			gts_pkg::ST_IDLE: begin
				if (in_take && action == gts_pkg::ACT_TICK) begin
					state_d = gts_pkg::ST_DECIDE;
				end
			end
			gts_pkg::ST_DECIDE: state_d = gts_pkg::ST_COPY;
			gts_pkg::ST_COPY: begin
				if (swept_q && status.sweep_done) begin
					state_d = gts_pkg::ST_EMIT;
				end
			end
			gts_pkg::ST_EMIT: begin
				if (status.emit_last && (!ov_q || out_take)) begin
					state_d = gts_pkg::ST_IDLE;
				end
			end
			default: state_d = gts_pkg::ST_IDLE;
		endcase
	end

	// decide registers the tick fields held stable while stalled
	always_comb begin
		cmd = '0;
		case (state_q)
			gts_pkg::ST_IDLE: cmd.decide = in_take && action == gts_pkg::ACT_TICK;
			gts_pkg::ST_DECIDE: cmd.sweep_start = 1'b1;
			gts_pkg::ST_COPY: cmd.sweep_en = !swept_q;
			gts_pkg::ST_EMIT: cmd.emit_en = !ov_q || out_take;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gts_pkg::ST_IDLE;
			ov_q <= 1'b0;
			swept_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_en) begin
				ov_q <= 1'b1;
			end else if (out_take) begin
				ov_q <= 1'b0;
			end
			// set once the read of the last motor has been issued
			if (state_q == gts_pkg::ST_DECIDE) begin
				swept_q <= 1'b0;
			end else if (cmd.sweep_en && status.emit_last) begin
				swept_q <= 1'b1;
			end
		end
	end

	no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != gts_pkg::ST_IDLE) |-> !in_take) else $error("input taken while busy");
	emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_en |-> (!ov_q || !out_stall)) else $error("result overwritten");
	tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |=> state_q == gts_pkg::ST_DECIDE) else $error("tick not started");
endmodule
